/* rtl/core/lodhs_pkg.sv */
package lodhs_pkg;

    // Field and datapath widths
    localparam int unsigned RadW    = 20;   // screen radius, 12.8 px
    localparam int unsigned ThrW    = 20;   // error threshold, 12.8 px
    localparam int unsigned ErrW    = 24;   // level errors and bounding radius
    localparam int unsigned LevelW  = 2;
    localparam int unsigned HoldW   = 16;
    localparam int unsigned ProdW   = 2 * ErrW;       // multiplier product
    localparam int unsigned DivW    = 45;             // dividend of boundary division
    localparam int unsigned CmpW    = DivW + 4;       // eleven times the quotient
    localparam int unsigned DivCntW = $clog2(DivW);
    localparam int unsigned AddrW   = 5;
    localparam int unsigned DataW   = 32;
    localparam int unsigned InBytesW  = 24;
    localparam int unsigned OutBytesW = 8;

    // Minimum number of ticks between level changes
    localparam logic [HoldW-1:0] HoldTicks = 16'd8;
    localparam logic [HoldW-1:0] HoldMax   = 16'hFFFF;

    // Detail levels
    localparam logic [LevelW-1:0] LVL_MESH  = 2'd0;
    localparam logic [LevelW-1:0] LVL_MICRO = 2'd1;
    localparam logic [LevelW-1:0] LVL_SPLAT = 2'd2;
    localparam logic [LevelW-1:0] LVL_GLINT = 2'd3;

    // Register map, word index
    typedef enum logic [2:0] {
        REG_THRESHOLD = 3'd0,
        REG_MICRO     = 3'd1,
        REG_SPLAT     = 3'd2,
        REG_GLINT     = 3'd3,
        REG_RADIUS    = 3'd4
    } reg_idx_t;

    // Register reset values
    localparam logic [ThrW-1:0] ThresholdRst = 20'd512;
    localparam logic [ErrW-1:0] LevelErrRst  = 24'd0;
    localparam logic [ErrW-1:0] RadiusRst    = 24'd65536;

    // Divider request and response
    typedef struct packed {
        logic            start;
        logic [DivW-1:0] dividend;
        logic [ErrW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic [DivW-1:0] quotient;
    } div_rsp_t;

endpackage

/* rtl/core/lodhs_divider.sv */
// Restoring divider, one quotient bit per cycle, most significant first.
module lodhs_divider (
    input  logic                aclk,
    input  logic                aresetn,
    input  lodhs_pkg::div_req_t req,
    output lodhs_pkg::div_rsp_t rsp
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [lodhs_pkg::DivCntW-1:0]  cnt_reg;
    logic [lodhs_pkg::ErrW-1:0]     rem_reg;
    logic [lodhs_pkg::DivW-1:0]     quo_reg;
    logic [lodhs_pkg::ErrW-1:0]     dsr_reg;

    logic [lodhs_pkg::ErrW:0]       shifted;
    logic [lodhs_pkg::ErrW:0]       diff;
    logic                           ge;

    // Bring down the next dividend bit and trial-subtract
    always_comb begin
        shifted = {rem_reg, quo_reg[lodhs_pkg::DivW-1]};
        diff    = shifted - {1'b0, dsr_reg};
        ge      = shifted >= {1'b0, dsr_reg};
    end

    // Sequence control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= lodhs_pkg::DivCntW'(lodhs_pkg::DivW - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge aclk) begin
        if (req.start && !busy_reg) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[lodhs_pkg::ErrW-1:0] : shifted[lodhs_pkg::ErrW-1:0];
            quo_reg <= {quo_reg[lodhs_pkg::DivW-2:0], ge};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* rtl/core/lod_rung_hysteresis_selector_unit.sv */
// Level-of-detail selector with hysteresis and minimum hold.
// Input channel s_*: one item per object per frame carries the projected
// screen radius. Result channel m_*: one item per input item carries the
// chosen level (0 mesh .. 3 glint) and a flag that is set when it changed.
// The APB port holds the threshold, the three level errors and the bounding
// radius; write it only while no item is in flight.
// One item is worked on at a time by a single 24x24 multiplier and a
// bit-serial divider under a small sequencer. Each item takes one multiply
// per level tried, and when a level change must be checked against its
// boundary, it also waits for the 45-step boundary division.
// s_tready rises again once the result is in the output register, so a new
// item may be taken while that result waits. If the receiver stalls, the
// next result waits in the sequencer and no further item is accepted.
// Reset returns the level to full mesh, clears the hold counter, loads the
// register reset values and empties the output register.
module lod_rung_hysteresis_selector_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lodhs_pkg::InBytesW-1:0]   s_tdata,   // [19:0] screen_radius
    // Result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lodhs_pkg::OutBytesW-1:0]  m_tdata,   // [1:0] level, [2] switched
    // Configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lodhs_pkg::AddrW-1:0]      paddr,
    input  logic [lodhs_pkg::DataW-1:0]      pwdata,
    output logic [lodhs_pkg::DataW-1:0]      prdata,
    output logic                             pready
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MLIM = 8'b0000_0010,
        S_MERR = 8'b0000_0100,
        S_CHK  = 8'b0000_1000,
        S_PREP = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_FIN  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    state_t                              state_reg;

    logic [lodhs_pkg::ThrW-1:0]          thr_reg;
    logic [lodhs_pkg::ErrW-1:0]          micro_reg;
    logic [lodhs_pkg::ErrW-1:0]          splat_reg;
    logic [lodhs_pkg::ErrW-1:0]          glint_reg;
    logic [lodhs_pkg::ErrW-1:0]          brad_reg;

    logic [lodhs_pkg::RadW-1:0]          radius_reg;
    logic [lodhs_pkg::LevelW-1:0]        lv_reg;
    logic [lodhs_pkg::LevelW-1:0]        raw_reg;
    logic [lodhs_pkg::LevelW-1:0]        cur_reg;
    logic [lodhs_pkg::HoldW-1:0]         hold_reg;
    logic [lodhs_pkg::ProdW-1:0]         prod_reg;
    logic [lodhs_pkg::ProdW-1:0]         limit_reg;
    logic [lodhs_pkg::DivW-1:0]          quot_reg;
    logic                                up_reg;
    logic [lodhs_pkg::LevelW-1:0]        res_level_reg;
    logic                                res_sw_reg;
    logic                                m_tvalid_reg;
    logic [lodhs_pkg::LevelW-1:0]        m_level_reg;
    logic                                m_sw_reg;

    logic                                cfg_wr;
    lodhs_pkg::reg_idx_t                 cfg_idx;
    logic [lodhs_pkg::ErrW-1:0]          r_eff;
    logic [lodhs_pkg::ErrW-1:0]          half_r;
    logic [lodhs_pkg::LevelW-1:0]        err_idx;
    logic [lodhs_pkg::ErrW-1:0]          err_sel;
    logic [lodhs_pkg::ErrW-1:0]          mul_a;
    logic [lodhs_pkg::ErrW-1:0]          mul_b;
    logic                                pass;
    logic                                coarsen;
    logic [lodhs_pkg::LevelW-1:0]        tgt;
    logic                                no_switch;
    logic [lodhs_pkg::ProdW-1:0]         dividend;
    logic [lodhs_pkg::HoldW-1:0]         hold_bump;
    logic [lodhs_pkg::CmpW-1:0]          r10;
    logic [lodhs_pkg::CmpW-1:0]          q9;
    logic [lodhs_pkg::CmpW-1:0]          q11;
    logic                                ok;
    logic                                out_free;
    lodhs_pkg::div_req_t                 div_req;
    lodhs_pkg::div_rsp_t                 div_rsp;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = lodhs_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg   <= lodhs_pkg::ThresholdRst;
            micro_reg <= lodhs_pkg::LevelErrRst;
            splat_reg <= lodhs_pkg::LevelErrRst;
            glint_reg <= lodhs_pkg::LevelErrRst;
            brad_reg  <= lodhs_pkg::RadiusRst;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                lodhs_pkg::REG_THRESHOLD: thr_reg   <= pwdata[lodhs_pkg::ThrW-1:0];
                lodhs_pkg::REG_MICRO:     micro_reg <= pwdata[lodhs_pkg::ErrW-1:0];
                lodhs_pkg::REG_SPLAT:     splat_reg <= pwdata[lodhs_pkg::ErrW-1:0];
                lodhs_pkg::REG_GLINT:     glint_reg <= pwdata[lodhs_pkg::ErrW-1:0];
                lodhs_pkg::REG_RADIUS:    brad_reg  <= pwdata[lodhs_pkg::ErrW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            lodhs_pkg::REG_THRESHOLD: prdata = lodhs_pkg::DataW'(thr_reg);
            lodhs_pkg::REG_MICRO:     prdata = lodhs_pkg::DataW'(micro_reg);
            lodhs_pkg::REG_SPLAT:     prdata = lodhs_pkg::DataW'(splat_reg);
            lodhs_pkg::REG_GLINT:     prdata = lodhs_pkg::DataW'(glint_reg);
            lodhs_pkg::REG_RADIUS:    prdata = lodhs_pkg::DataW'(brad_reg);
            default:                  prdata = '0;
        endcase
    end

    // Effective bounding radius; zero counts as one
    assign r_eff  = (brad_reg == '0) ? lodhs_pkg::ErrW'(1) : brad_reg;
    assign half_r = r_eff >> 1;

    // Level error select: the level under test, or the boundary level in PREP
    assign coarsen = raw_reg > cur_reg;
    assign tgt     = coarsen ? raw_reg : cur_reg;
    assign err_idx = (state_reg == S_PREP) ? tgt : lv_reg;

    always_comb begin
        case (err_idx)
            lodhs_pkg::LVL_MICRO: err_sel = micro_reg;
            lodhs_pkg::LVL_SPLAT: err_sel = splat_reg;
            lodhs_pkg::LVL_GLINT: err_sel = glint_reg;
            default:              err_sel = '0;
        endcase
    end

    // Shared multiplier: (threshold + 1) * radius first, then radius * level error
    always_comb begin
        if (state_reg == S_MLIM) begin
            mul_a = lodhs_pkg::ErrW'({1'b0, thr_reg} + 21'd1);
            mul_b = r_eff;
        end else begin
            mul_a = lodhs_pkg::ErrW'(radius_reg);
            mul_b = err_sel;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Rounded screen error within threshold, written as one compare
    assign pass = (err_sel == '0) ||
                  ((prod_reg + lodhs_pkg::ProdW'(half_r)) < limit_reg);

    // Boundary dividend: threshold * radius plus half the level error
    assign dividend = (limit_reg - lodhs_pkg::ProdW'(r_eff)) +
                      lodhs_pkg::ProdW'(err_sel >> 1);

    assign no_switch = (raw_reg == cur_reg) || (hold_reg < lodhs_pkg::HoldTicks);
    assign hold_bump = (hold_reg == lodhs_pkg::HoldMax) ? hold_reg : hold_reg + 1'b1;

    // Hysteresis margin against the boundary
    assign r10 = lodhs_pkg::CmpW'({radius_reg, 3'b000}) +
                 lodhs_pkg::CmpW'({radius_reg, 1'b0});
    assign q9  = lodhs_pkg::CmpW'({quot_reg, 3'b000}) + lodhs_pkg::CmpW'(quot_reg);
    assign q11 = q9 + lodhs_pkg::CmpW'({quot_reg, 1'b0});
    assign ok  = up_reg ? (r10 <= q9) : (r10 >= q11);

    assign div_req.start    = (state_reg == S_PREP) && !no_switch && (err_sel != '0);
    assign div_req.dividend = dividend[lodhs_pkg::DivW-1:0];
    assign div_req.divisor  = err_sel;

    lodhs_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    // Sequencer and level state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cur_reg   <= lodhs_pkg::LVL_MESH;
            hold_reg  <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: if (s_tvalid) state_reg <= S_MLIM;
                S_MLIM: state_reg <= S_MERR;
                S_MERR: state_reg <= S_CHK;
                S_CHK: begin
                    if (pass || lv_reg == lodhs_pkg::LVL_MICRO) state_reg <= S_PREP;
                    else state_reg <= S_MERR;
                end
                S_PREP: begin
                    if (no_switch) begin
                        hold_reg  <= hold_bump;
                        state_reg <= S_OUT;
                    end else if (err_sel == '0) begin
                        state_reg <= S_FIN;
                    end else begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: if (div_rsp.done) state_reg <= S_FIN;
                S_FIN: begin
                    if (ok) begin
                        cur_reg  <= raw_reg;
                        hold_reg <= '0;
                    end else begin
                        hold_reg <= hold_bump;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: if (out_free) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Working values of the item in flight
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_tvalid) begin
            radius_reg <= s_tdata[lodhs_pkg::RadW-1:0];
            lv_reg     <= lodhs_pkg::LVL_GLINT;
        end
        if (state_reg == S_MERR && lv_reg == lodhs_pkg::LVL_GLINT) begin
            limit_reg <= prod_reg;
        end
        if (state_reg == S_CHK) begin
            if (pass) raw_reg <= lv_reg;
            else if (lv_reg == lodhs_pkg::LVL_MICRO) raw_reg <= lodhs_pkg::LVL_MESH;
            else lv_reg <= lv_reg - 1'b1;
        end
        if (state_reg == S_PREP) begin
            up_reg        <= coarsen;
            quot_reg      <= '0;
            res_level_reg <= cur_reg;
            res_sw_reg    <= 1'b0;
        end
        if (state_reg == S_DIV && div_rsp.done) begin
            quot_reg <= div_rsp.quotient;
        end
        if (state_reg == S_FIN) begin
            res_level_reg <= ok ? raw_reg : cur_reg;
            res_sw_reg    <= ok;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == S_OUT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && out_free) begin
            m_level_reg <= res_level_reg;
            m_sw_reg    <= res_sw_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b00000, m_sw_reg, m_level_reg};

`ifndef NO_ASSERTIONS
    a_switch_clears_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && res_sw_reg) |-> (hold_reg == '0))
        else $error("switched result with nonzero hold count");

    a_div_only_in_div : assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.busy |-> (state_reg == S_DIV))
        else $error("divider busy outside the divide state");

    a_div_done_to_fin : assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |=> (state_reg == S_FIN))
        else $error("divider result not taken");

    a_chk_level : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHK) |-> (lv_reg != lodhs_pkg::LVL_MESH))
        else $error("mesh level tested against threshold");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    // Expected level and switch flag of one item
    typedef struct packed {
        logic [lodhs_pkg::LevelW-1:0] level;
        logic                         switched;
    } lod_pick_t;

    // First register index that is not in the map
    localparam logic [2:0] RegPastEnd = 3'd5;

    logic                                aclk     = 1'b0;
    logic                                aresetn  = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [lodhs_pkg::InBytesW-1:0]      s_tdata  = '0;   // [19:0] screen_radius
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [lodhs_pkg::OutBytesW-1:0]     m_tdata;         // [1:0] level, [2] switched
    logic                                psel     = 1'b0;
    logic                                penable  = 1'b0;
    logic                                pwrite   = 1'b0;
    logic [lodhs_pkg::AddrW-1:0]         paddr    = '0;
    logic [lodhs_pkg::DataW-1:0]         pwdata   = '0;
    logic [lodhs_pkg::DataW-1:0]         prdata;
    logic                                pready;

    // Shadow of the registers and of the selector state
    logic [lodhs_pkg::ThrW-1:0]          thr_cfg  = lodhs_pkg::ThresholdRst;
    logic [lodhs_pkg::ErrW-1:0]          lvl_err [4] = '{default: lodhs_pkg::LevelErrRst};
    logic [lodhs_pkg::ErrW-1:0]          rad_cfg  = lodhs_pkg::RadiusRst;
    logic [lodhs_pkg::LevelW-1:0]        lvl_now  = lodhs_pkg::LVL_MESH;
    logic [lodhs_pkg::HoldW-1:0]         hold_now = '0;

    logic [lodhs_pkg::RadW-1:0]          radius_q [$];
    lod_pick_t                           level_q [$];
    int unsigned                         radii_queued   = 0;
    int unsigned                         levels_checked = 0;
    int unsigned                         fail_count     = 0;
    int unsigned                         in_wait        = 0;
    int unsigned                         out_wait       = 0;
    logic                                calm           = 1'b1;

    lod_rung_hysteresis_selector_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // Level boundary: threshold times bounding radius over the level error, rounded
    function automatic logic [63:0] rung_edge(input logic [lodhs_pkg::LevelW-1:0] lv);
        logic [63:0] err;
        logic [63:0] den;
        err = 64'(lvl_err[lv]);
        den = (rad_cfg == '0) ? 64'd1 : 64'(rad_cfg);
        if (err == 64'd0) begin
            return 64'd0;
        end
        return (64'(thr_cfg) * den + err / 2) / err;
    endfunction

    // Advance the selector by one radius and return what it shows
    function automatic lod_pick_t select_level(input logic [lodhs_pkg::RadW-1:0] radius);
        logic [63:0]                  r64;
        logic [63:0]                  den;
        logic [63:0]                  scr;
        logic [63:0]                  bound;
        logic [lodhs_pkg::LevelW-1:0] raw;
        logic                         pass;
        lod_pick_t                    pick;
        r64  = 64'(radius);
        den  = (rad_cfg == '0) ? 64'd1 : 64'(rad_cfg);
        raw  = lodhs_pkg::LVL_MESH;
        pass = 1'b0;
        // coarsest level whose screen error fits the budget
        for (int lv = lodhs_pkg::LVL_GLINT; lv >= lodhs_pkg::LVL_MICRO; lv--) begin
            scr = (lvl_err[lv] == '0) ? 64'd0 : (r64 * lvl_err[lv] + den / 2) / den;
            if (raw == lodhs_pkg::LVL_MESH && scr <= 64'(thr_cfg)) begin
                raw = lodhs_pkg::LevelW'(lv);
            end
        end
        // change only after the hold and past the 10% margin
        if (raw != lvl_now && hold_now >= lodhs_pkg::HoldTicks) begin
            bound = rung_edge((raw > lvl_now) ? raw : lvl_now);
            pass  = (raw > lvl_now) ? (r64 * 10 <= bound * 9) : (r64 * 10 >= bound * 11);
        end
        pick.switched = pass;
        if (pass) begin
            lvl_now  = raw;
            hold_now = '0;
        end else if (hold_now != lodhs_pkg::HoldMax) begin
            hold_now = hold_now + 1'b1;
        end
        pick.level = lvl_now;
        return pick;
    endfunction

    function automatic int unsigned pick_wait();
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    // Level error aimed so that its boundary mostly lands inside the radius range
    function automatic logic [lodhs_pkg::ErrW-1:0] pick_level_error();
        logic [63:0] aim;
        logic [63:0] err;
        case ($urandom_range(0, 5))
            0: err = '0;
            1: err = 64'({lodhs_pkg::ErrW{1'b1}});
            2: err = 64'($urandom_range(0, (1 << lodhs_pkg::ErrW) - 1));
            default: begin
                aim = 64'($urandom_range(1, (1 << $urandom_range(1, lodhs_pkg::RadW)) - 1));
                err = (64'(thr_cfg) * ((rad_cfg == '0) ? 64'd1 : 64'(rad_cfg)) + aim / 2)
                      / aim;
                if (err > 64'({lodhs_pkg::ErrW{1'b1}})) begin
                    err = 64'({lodhs_pkg::ErrW{1'b1}});
                end
            end
        endcase
        return err[lodhs_pkg::ErrW-1:0];
    endfunction

    task automatic enqueue_radius(input logic [lodhs_pkg::RadW-1:0] radius);
        radius_q.insert(radius_q.size(), radius);
        radii_queued++;
    endtask

    task automatic wait_drained();
        wait (levels_checked >= radii_queued);
        @(posedge aclk);
    endtask

    // Write one register over APB, then read it back
    task automatic cfg_write(input logic [2:0] idx, input logic [lodhs_pkg::DataW-1:0] val);
        logic [lodhs_pkg::DataW-1:0] held;
        logic                        mapped;
        mapped = 1'b1;
        held   = '0;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        // register takes the value at this edge
        case (idx)
            lodhs_pkg::REG_THRESHOLD: begin
                thr_cfg = val[lodhs_pkg::ThrW-1:0];
                held    = lodhs_pkg::DataW'(thr_cfg);
            end
            lodhs_pkg::REG_MICRO, lodhs_pkg::REG_SPLAT, lodhs_pkg::REG_GLINT: begin
                lvl_err[idx[1:0]] = val[lodhs_pkg::ErrW-1:0];
                held              = lodhs_pkg::DataW'(val[lodhs_pkg::ErrW-1:0]);
            end
            lodhs_pkg::REG_RADIUS: begin
                rad_cfg = val[lodhs_pkg::ErrW-1:0];
                held    = lodhs_pkg::DataW'(rad_cfg);
            end
            default: mapped = 1'b0;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (mapped && prdata !== held) begin
            $display("%0t: register %0d readback mismatch, expected %0h, actual %0h",
                     $time, idx, held, prdata);
            fail_count++;
        end
    endtask

    // Present queued radii, predicting each item as it is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            in_wait  <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                level_q.insert(level_q.size(), select_level(s_tdata[lodhs_pkg::RadW-1:0]));
            end
            if (!s_tvalid || s_tready) begin
                if (in_wait != 0) begin
                    in_wait  <= in_wait - 1;
                    s_tvalid <= 1'b0;
                end else if (radius_q.size() != 0) begin
                    s_tdata  <= lodhs_pkg::InBytesW'(radius_q.pop_front());
                    s_tvalid <= 1'b1;
                    in_wait  <= pick_wait();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Take results, compare with the oldest expected level, stall at random
    always @(posedge aclk) begin : result_mon
        int unsigned stall;
        lod_pick_t   due;
        if (!aresetn) begin
            m_tready <= 1'b0;
            out_wait <= 0;
        end else begin
            stall = out_wait;
            if (m_tvalid && m_tready) begin
                levels_checked++;
                stall = pick_wait();
                if (level_q.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual level %0d switched %0b",
                             $time, m_tdata[lodhs_pkg::LevelW-1:0], m_tdata[lodhs_pkg::LevelW]);
                    fail_count++;
                end else begin
                    due = level_q.pop_front();
                    if (m_tdata[lodhs_pkg::LevelW-1:0] !== due.level) begin
                        $display("%0t: level mismatch, expected %0d, actual %0d",
                                 $time, due.level, m_tdata[lodhs_pkg::LevelW-1:0]);
                        fail_count++;
                    end
                    if (m_tdata[lodhs_pkg::LevelW] !== due.switched) begin
                        $display("%0t: switched mismatch, expected %0b, actual %0b",
                                 $time, due.switched, m_tdata[lodhs_pkg::LevelW]);
                        fail_count++;
                    end
                end
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                out_wait <= stall - 1;
            end else begin
                m_tready <= 1'b1;
                out_wait <= 0;
            end
        end
    end

    initial begin
        int unsigned left;
        int unsigned run;
        logic [63:0] centre;
        logic [63:0] radius;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Stay on mesh past the minimum hold, then coarsen straight to glint at zero radius
        calm = 1'b1;
        cfg_write(lodhs_pkg::REG_THRESHOLD, '0);
        cfg_write(lodhs_pkg::REG_RADIUS, 1);
        cfg_write(lodhs_pkg::REG_MICRO, lodhs_pkg::DataW'({lodhs_pkg::ErrW{1'b1}}));
        cfg_write(lodhs_pkg::REG_SPLAT, lodhs_pkg::DataW'({lodhs_pkg::ErrW{1'b1}}));
        cfg_write(lodhs_pkg::REG_GLINT, lodhs_pkg::DataW'({lodhs_pkg::ErrW{1'b1}}));
        repeat (int'(lodhs_pkg::HoldTicks) + 4) enqueue_radius({lodhs_pkg::RadW{1'b1}});
        enqueue_radius('0);
        wait_drained();

        // Directed: refine after the hold, coarsen at zero radius, refine blocked by the margin
        calm = 1'b0;
        cfg_write(lodhs_pkg::REG_THRESHOLD, 512);
        cfg_write(lodhs_pkg::REG_RADIUS, 65536);
        cfg_write(lodhs_pkg::REG_MICRO, 4096);
        cfg_write(lodhs_pkg::REG_SPLAT, 16384);
        cfg_write(lodhs_pkg::REG_GLINT, 65536);
        repeat (9) enqueue_radius({lodhs_pkg::RadW{1'b1}});
        repeat (9) enqueue_radius('0);
        repeat (9) enqueue_radius(540);
        enqueue_radius(480);
        wait_drained();

        // Random phases, each with its own register setting
        for (int ph = 0; ph < 12; ph++) begin
            calm = ($urandom_range(0, 3) == 0);
            case (ph)
                0: begin
                    cfg_write(lodhs_pkg::REG_THRESHOLD,
                              lodhs_pkg::DataW'({lodhs_pkg::ThrW{1'b1}}));
                    cfg_write(lodhs_pkg::REG_RADIUS,
                              lodhs_pkg::DataW'({lodhs_pkg::ErrW{1'b1}}));
                end
                1: begin
                    cfg_write(lodhs_pkg::REG_THRESHOLD, '0);
                    cfg_write(lodhs_pkg::REG_RADIUS, '0);
                end
                2: begin
                    cfg_write(lodhs_pkg::REG_THRESHOLD, $urandom_range(16, 8192));
                    cfg_write(lodhs_pkg::REG_RADIUS, 1);
                end
                default: begin
                    cfg_write(lodhs_pkg::REG_THRESHOLD, ($urandom_range(0, 3) == 0) ?
                              $urandom_range(0, (1 << lodhs_pkg::ThrW) - 1) :
                              $urandom_range(16, 8192));
                    cfg_write(lodhs_pkg::REG_RADIUS, ($urandom_range(0, 3) == 0) ?
                              $urandom_range(0, (1 << lodhs_pkg::ErrW) - 1) :
                              $urandom_range(256, 1 << 20));
                end
            endcase
            cfg_write(lodhs_pkg::REG_MICRO, lodhs_pkg::DataW'(pick_level_error()));
            cfg_write(lodhs_pkg::REG_SPLAT, lodhs_pkg::DataW'(pick_level_error()));
            cfg_write(lodhs_pkg::REG_GLINT, lodhs_pkg::DataW'(pick_level_error()));
            if ($urandom_range(0, 2) == 0) begin
                cfg_write(3'(RegPastEnd + $urandom_range(0, 2)), $urandom);
            end

            // runs of close radii, mostly around the level boundaries
            left = 120;
            while (left != 0) begin
                case ($urandom_range(0, 7))
                    5: centre = 64'($urandom_range(0, (1 << lodhs_pkg::RadW) - 1));
                    6: centre = ($urandom_range(0, 1) == 0) ? 64'd0 :
                                64'({lodhs_pkg::RadW{1'b1}});
                    7: centre = 64'($urandom_range(0, 1023));
                    default: centre = rung_edge(lodhs_pkg::LevelW'($urandom_range(1, 3)))
                                      * $urandom_range(80, 120) / 100;
                endcase
                run = $urandom_range(1, 14);
                if (run > left) begin
                    run = left;
                end
                repeat (run) begin
                    radius = centre * $urandom_range(98, 102) / 100 + $urandom_range(0, 2);
                    if (radius > 64'({lodhs_pkg::RadW{1'b1}})) begin
                        radius = 64'({lodhs_pkg::RadW{1'b1}});
                    end
                    enqueue_radius(radius[lodhs_pkg::RadW-1:0]);
                end
                left -= run;
            end
            wait_drained();
        end

        // Let any stray item surface before the verdict
        repeat (64) @(posedge aclk);
        if (level_q.size() != 0) begin
            $display("%0t: %0d expected levels never arrived, actual none", $time, level_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("lod_rung_hysteresis_selector_unit verification clean");
        end else begin
            $display("lod_rung_hysteresis_selector_unit verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(30_000_000);
        $display("lod_rung_hysteresis_selector_unit verification failed");
        $finish;
    end

endmodule
